@@ src/ordered_set_engine_macros.svh @@
// -----------------------------------------------------------------------------
// ordered_set_engine_macros.svh
// Assertion helpers shared by the ordered set engine RTL.
// -----------------------------------------------------------------------------
`ifndef ORDERED_SET_ENGINE_MACROS_SVH
`define ORDERED_SET_ENGINE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define OSE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ordered set engine: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define OSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ordered set engine: next-cycle check failed");

`endif

@@ src/ose_pkg.sv @@
// -----------------------------------------------------------------------------
// ose_pkg
// Types, sizes and request codes for the ordered set engine.
// -----------------------------------------------------------------------------
`default_nettype none

package ose_pkg;

    // Table size and field widths
    localparam int CAPACITY  = 64;
    localparam int KEY_W     = 64;
    localparam int REQ_W     = 3;

    // Neighbor select tree: groups of cells ORed in the first stage
    localparam int TREE_GRP  = 8;
    localparam int TREE_NGRP = (CAPACITY + TREE_GRP - 1) / TREE_GRP;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_EXISTS = 3'd2;
    localparam logic [REQ_W-1:0] REQ_NEXT   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_PREV   = 3'd4;

    typedef logic signed [KEY_W-1:0] t_key;

    // What one cell shows its neighbors
    typedef struct packed {
        t_key key;
        logic occ;   // cell holds a key
        logic gt;    // stored key > request key
        logic lt;    // stored key < request key
    } t_link;

    // Broadcast control to every cell
    typedef struct packed {
        logic cmp;   // capture compare flags
        logic ins;   // shift right and insert
        logic del;   // shift left over the matching cell
        logic nxt;   // offer the next-greater key
        logic prv;   // offer the previous-smaller key
    } t_cell_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD,
        S_RED
    } t_state;

endpackage

`default_nettype wire

@@ src/ose_if.sv @@
// -----------------------------------------------------------------------------
// ose_if
// Valid/ready channels for requests and results of the ordered set engine.
// -----------------------------------------------------------------------------
`default_nettype none

interface ose_req_if import ose_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    t_key             key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

interface ose_rsp_if import ose_pkg::*; ();
    logic valid;
    logic ready;
    logic found;
    t_key neighbor_key;
    logic insert_dropped;

    modport source (output valid, output found, output neighbor_key,
                    output insert_dropped, input ready);
    modport sink   (input valid, input found, input neighbor_key,
                    input insert_dropped, output ready);
endinterface

`default_nettype wire

@@ src/ose_cell.sv @@
// -----------------------------------------------------------------------------
// ose_cell
// One slot of the sorted key row: compares, shifts with its neighbors.
// -----------------------------------------------------------------------------
`default_nettype none

module ose_cell import ose_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_key       i_key,
    input  t_cell_ctl  i_ctl,
    input  t_link      i_left,
    input  t_link      i_right,
    output t_link      o_link,
    output logic       o_eq,
    output logic       o_pick
);

    t_key r_key;
    logic r_occ;
    logic r_gt;
    logic r_eq;

    logic w_lt;
    logic w_m;
    logic w_m_left;
    logic w_ge;

    // Position flags relative to the request key
    assign w_lt     = r_occ && !r_gt && !r_eq;
    assign w_m      = !r_occ || r_gt;           // at or past the insert point
    assign w_m_left = !i_left.occ || i_left.gt;
    assign w_ge     = r_gt || r_eq;             // at or past the delete point

    // Stored key: insert shifts right, delete shifts left
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins && w_m) begin
            r_key <= w_m_left ? i_left.key : i_key;
        end else if (i_ctl.del && w_ge) begin
            r_key <= i_right.key;
        end
    end

    // Occupancy moves with the keys
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctl.ins && w_m) begin
            r_occ <= r_occ || i_left.occ;
        end else if (i_ctl.del && w_ge) begin
            r_occ <= i_right.occ;
        end
    end

    // Compare flags against the broadcast key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gt <= 1'b0;
            r_eq <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_gt <= r_occ && (r_key > i_key);
            r_eq <= r_occ && (r_key == i_key);
        end
    end

    // First greater cell answers next, last smaller cell answers prev
    assign o_pick = (i_ctl.nxt && r_gt && !i_left.gt) ||
                    (i_ctl.prv && w_lt && !i_right.lt);

    assign o_eq        = r_eq;
    assign o_link.key  = r_key;
    assign o_link.occ  = r_occ;
    assign o_link.gt   = r_gt;
    assign o_link.lt   = w_lt;

endmodule

`default_nettype wire

@@ src/ose_tree.sv @@
// -----------------------------------------------------------------------------
// ose_tree
// Registered OR tree that gathers the one picked key from the cell row.
// -----------------------------------------------------------------------------
`default_nettype none

module ose_tree import ose_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  logic [CAPACITY-1:0]  i_pick,
    input  t_key                 i_key [CAPACITY],
    output logic                 o_hit,
    output t_key                 o_key
);

    localparam int PAD = TREE_NGRP * TREE_GRP;

    t_key w_mkey [PAD];
    logic w_mpick [PAD];
    t_key w_gkey [TREE_NGRP];
    logic w_ghit [TREE_NGRP];
    t_key r_gkey [TREE_NGRP];
    logic r_ghit [TREE_NGRP];

    // Masked keys, padded to whole groups
    for (genvar c = 0; c < PAD; c++) begin : g_mask
        if (c < CAPACITY) begin : g_real
            assign w_mkey[c]  = i_pick[c] ? i_key[c] : '0;
            assign w_mpick[c] = i_pick[c];
        end else begin : g_pad
            assign w_mkey[c]  = '0;
            assign w_mpick[c] = 1'b0;
        end
    end

    // First stage: OR within each group
    for (genvar g = 0; g < TREE_NGRP; g++) begin : g_grp
        always_comb begin
            w_gkey[g] = '0;
            w_ghit[g] = 1'b0;
            for (int j = 0; j < TREE_GRP; j++) begin
                w_gkey[g] = w_gkey[g] | w_mkey[g*TREE_GRP + j];
                w_ghit[g] = w_ghit[g] | w_mpick[g*TREE_GRP + j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ghit[g] <= 1'b0;
            end else begin
                r_ghit[g] <= w_ghit[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_gkey[g] <= w_gkey[g];
        end
    end

    // Second stage: OR across groups
    always_comb begin
        o_key = '0;
        o_hit = 1'b0;
        for (int g = 0; g < TREE_NGRP; g++) begin
            o_key = o_key | r_gkey[g];
            o_hit = o_hit | r_ghit[g];
        end
    end

endmodule

`default_nettype wire

@@ src/ordered_set_engine.sv @@
// -----------------------------------------------------------------------------
// ordered_set_engine: sorted row of key cells with insert/delete/lookup.
// A request passes the compare, update (shift/select) and reduce (OR-tree) states;
// a new request is taken only in idle, once the result register has loaded the last.
// Sync active-low reset empties the set and clears the result valid flag.
// -----------------------------------------------------------------------------
`default_nettype none
`include "ordered_set_engine_macros.svh"

module ordered_set_engine import ose_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    ose_req_if.sink     i_req,
    ose_rsp_if.source   o_rsp
);

    t_state           r_state;
    t_state           n_state;

    logic [REQ_W-1:0] r_req;
    t_key             r_key;
    logic             r_found_pre;
    logic             r_drop;
    logic             r_isnb;

    logic             r_ovalid;
    logic             r_o_found;
    t_key             r_o_key;
    logic             r_o_drop;

    t_cell_ctl        w_ctl;
    t_link            w_link  [CAPACITY];
    t_link            w_left  [CAPACITY];
    t_link            w_right [CAPACITY];
    t_key             w_ckey  [CAPACITY];
    logic [CAPACITY-1:0] w_eq;
    logic [CAPACITY-1:0] w_pick;
    logic [CAPACITY-1:0] w_occ;
    logic             w_present;
    logic             w_full;
    logic             w_load;
    logic             w_hit;
    t_key             w_tkey;

    localparam t_link LEFT_END  = '{key: '0, occ: 1'b1, gt: 1'b0, lt: 1'b1};
    localparam t_link RIGHT_END = '{key: '0, occ: 1'b0, gt: 1'b1, lt: 1'b0};

    // Cell row
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign w_left[i] = LEFT_END;
        end else begin : g_mid_l
            assign w_left[i] = w_link[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign w_right[i] = RIGHT_END;
        end else begin : g_mid_r
            assign w_right[i] = w_link[i+1];
        end

        ose_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_key   (r_key),
            .i_ctl   (w_ctl),
            .i_left  (w_left[i]),
            .i_right (w_right[i]),
            .o_link  (w_link[i]),
            .o_eq    (w_eq[i]),
            .o_pick  (w_pick[i])
        );

        assign w_occ[i]  = w_link[i].occ;
        assign w_ckey[i] = w_link[i].key;
    end

    // Neighbor gather
    ose_tree u_tree (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pick  (w_pick),
        .i_key   (w_ckey),
        .o_hit   (w_hit),
        .o_key   (w_tkey)
    );

    assign w_present = |w_eq;
    assign w_full    = w_occ[CAPACITY-1];
    assign w_load    = (r_state == S_RED) && (!r_ovalid || o_rsp.ready);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_req.valid) n_state = S_CMP;
            S_CMP:  n_state = S_UPD;
            S_UPD:  n_state = S_RED;
            S_RED:  if (w_load) n_state = S_IDLE;
        endcase
    end

    // State outputs; the neighbor pick stays up while the result step waits
    always_comb begin
        i_req.ready = (r_state == S_IDLE);
        w_ctl.cmp   = (r_state == S_CMP);
        w_ctl.ins   = (r_state == S_UPD) && (r_req == REQ_INSERT) && !w_present && !w_full;
        w_ctl.del   = (r_state == S_UPD) && (r_req == REQ_DELETE) && w_present;
        w_ctl.nxt   = ((r_state == S_UPD) || (r_state == S_RED)) && (r_req == REQ_NEXT);
        w_ctl.prv   = ((r_state == S_UPD) || (r_state == S_RED)) && (r_req == REQ_PREV);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req <= i_req.req_type;
            r_key <= i_req.key;
        end
    end

    // Membership outcome, taken during the update step
    always_ff @(posedge i_clk) begin
        if (r_state == S_UPD) begin
            r_found_pre <= w_present && ((r_req == REQ_INSERT) || (r_req == REQ_DELETE) ||
                                         (r_req == REQ_EXISTS));
            r_drop      <= (r_req == REQ_INSERT) && !w_present && w_full;
            r_isnb      <= (r_req == REQ_NEXT) || (r_req == REQ_PREV);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_found <= r_isnb ? w_hit : r_found_pre;
            r_o_key   <= r_isnb ? w_tkey : '0;
            r_o_drop  <= r_drop;
        end
    end

    assign o_rsp.valid          = r_ovalid;
    assign o_rsp.found          = r_o_found;
    assign o_rsp.neighbor_key   = r_o_key;
    assign o_rsp.insert_dropped = r_o_drop;

    // Checks
    `OSE_ASSERT_IMPL(a_occ_thermo, i_clk, i_rst_n, 1'b1, ((w_occ >> 1) & ~w_occ) == '0)
    `OSE_ASSERT_IMPL(a_pick_one, i_clk, i_rst_n, r_state == S_UPD, $onehot0(w_pick))
    `OSE_ASSERT_IMPL(a_eq_one, i_clk, i_rst_n, r_state == S_UPD, $onehot0(w_eq))
    `OSE_ASSERT_NEXT(a_ins_grow, i_clk, i_rst_n, w_ctl.ins, $countones(w_occ) == $past($countones(w_occ)) + 1)
    `OSE_ASSERT_NEXT(a_acc_cmp, i_clk, i_rst_n, i_req.valid && i_req.ready, r_state == S_CMP)

endmodule

`default_nettype wire
